/* src/tcq_pkg.sv */
// ============================================================================
// tcq_pkg: shared types and constants for the timer callout queue
// Holds the request codes, the field widths and the command and status
// structs that join the controller and the datapath.
// ============================================================================
package tcq_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int MAX_FIRES_PER_ADVANCE = 63;
   localparam int SLOT_W = $clog2(TIMER_SLOTS);
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam int FIA_W = 6;
   localparam int TIME_W = 64;
   localparam int STAMP_W = 32;

   typedef enum logic [1:0] {
      REQ_ARM     = 2'd0,
      REQ_CANCEL  = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_NOP     = 2'd3
   } req_code_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic                  load;      // capture the accepted request
      logic                  apply;     // apply arm or cancel
      logic                  set_time;  // advance: current time takes new_time
      logic                  scan_clr;  // start a minimum search
      logic                  scan_step; // examine one slot
      logic                  fire;      // fire the found slot
      logic                  emit;      // load the result register
      logic                  emit_fire; // the result reports a firing
      logic                  emit_last; // the result ends the item
   } ctl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      req_code_type          req;
      logic                  scan_done;
      logic                  found_due; // search found an armed slot that is due
      logic                  cap_hit;   // fire count has reached the cap
   } dp_sts_type;

endpackage

/* src/tcq_ctrl.sv */
// ============================================================================
// tcq_ctrl: sequencer for the timer callout queue
// Steps each request through apply, slot search, firing and result beats.
// ============================================================================
module tcq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   output logic                   req_ready,
   input  logic                   out_full,
   input  tcq_pkg::dp_sts_type    sts,
   output tcq_pkg::ctl_cmd_type   cmd
);
   import tcq_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_APPLY  = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_DECIDE = 7'b0001000,
      ST_FIRE   = 7'b0010000,
      ST_RESCAN = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      emit_fire_ff, emit_fire_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      emit_fire_in = emit_fire_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_fire;
            if (req_fire) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (sts.req == REQ_ADVANCE) begin
               cmd.set_time = 1'b1;
               emit_fire_in = 1'b0;
            end else begin
               cmd.apply = 1'b1;
            end
            cmd.scan_clr = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // The search result drives both the firing choice and next_expiry.
            if (sts.req == REQ_ADVANCE && sts.found_due && !sts.cap_hit
                && !emit_fire_ff) begin
               cmd.fire     = 1'b1;
               cmd.scan_clr = 1'b1;
               emit_fire_in = 1'b1;
               state_in     = ST_RESCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RESCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_full) begin
               cmd.emit      = 1'b1;
               cmd.emit_fire = emit_fire_ff;
               if (emit_fire_ff) begin
                  cmd.emit_last = !(sts.found_due && !sts.cap_hit);
                  emit_fire_in  = 1'b0;
                  if (sts.found_due && !sts.cap_hit) begin
                     state_in = ST_DECIDE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emit_fire_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_fire_ff <= emit_fire_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state register not one-hot");
   a_fire_after_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> state_ff == ST_DECIDE)
      else $error("firing outside decide");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_APPLY)
      else $error("load did not start apply");

endmodule

/* src/tcq_dp.sv */
// ============================================================================
// tcq_dp: slot table and search datapath for the timer callout queue
// Holds the slot table, scans it one slot a cycle for the earliest expiry
// and builds the result beat.
// ============================================================================
module tcq_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_type,
   input  logic [3:0]                    timer_id,
   input  logic [tcq_pkg::TIME_W-1:0]    delay,
   input  logic [tcq_pkg::TIME_W-1:0]    period,
   input  logic [tcq_pkg::TIME_W-1:0]    new_time,
   input  tcq_pkg::ctl_cmd_type          cmd,
   output tcq_pkg::dp_sts_type           sts,
   input  logic                          out_take,
   output logic                          out_full,
   output logic [151:0]                  out_data,
   output logic                          out_last
);
   import tcq_pkg::*;

   // Captured request.
   req_code_type             rq_ff;
   logic [3:0]               id_ff;
   logic [TIME_W-1:0]        delay_ff, period_ff, ntime_ff;

   logic [TIME_W-1:0]        cur_ff;
   logic [TIME_W-1:0]        exp_ff [TIMER_SLOTS];
   logic [TIME_W-1:0]        per_ff [TIMER_SLOTS];
   logic [STAMP_W-1:0]       stamp_ff [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0]   armed_ff;
   logic [STAMP_W-1:0]       ins_ff;
   logic [CNT_W-1:0]         armcnt_ff;
   logic [TIME_W-1:0]        total_ff;
   logic [FIA_W-1:0]         fia_ff;
   logic                     was_ff;
   logic [SLOT_W-1:0]        fslot_ff;

   // Search state.
   logic [SLOT_W:0]          scan_ff;
   logic                     found_ff;
   logic [SLOT_W-1:0]        best_ff;
   logic [TIME_W-1:0]        bexp_ff;
   logic [STAMP_W-1:0]       bage_ff;

   // Output register.
   logic                     full_ff;
   logic [151:0]             odata_ff;
   logic                     olast_ff;

   logic [SLOT_W-1:0]        cand;
   logic [TIME_W-1:0]        cexp;
   logic [STAMP_W-1:0]       cage;
   logic                     take_cand;
   logic                     id_ok;
   logic [SLOT_W-1:0]        sid;

   assign cand = scan_ff[SLOT_W-1:0];
   assign cexp = exp_ff[cand];
   assign cage = ins_ff - stamp_ff[cand];
   assign take_cand = armed_ff[cand] &&
      (!found_ff || cexp < bexp_ff || (cexp == bexp_ff && cage > bage_ff));
   assign id_ok = ({1'b0, id_ff} < (SLOT_W + 1)'(TIMER_SLOTS));
   assign sid = id_ff[SLOT_W-1:0];

   assign sts.req       = rq_ff;
   assign sts.scan_done = scan_ff == (SLOT_W + 1)'(TIMER_SLOTS - 1);
   assign sts.found_due = found_ff && bexp_ff <= ntime_ff;
   assign sts.cap_hit   = fia_ff == FIA_W'(MAX_FIRES_PER_ADVANCE);

   assign out_full = full_ff;
   assign out_data = odata_ff;
   assign out_last = olast_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_ff     <= req_code_type'(req_type);
         id_ff     <= timer_id;
         delay_ff  <= delay;
         period_ff <= period;
         ntime_ff  <= new_time;
      end
      if (cmd.apply && rq_ff == REQ_ARM && id_ok) begin
         per_ff[sid]   <= period_ff;
         exp_ff[sid]   <= cur_ff + delay_ff;
         stamp_ff[sid] <= ins_ff;
      end
      if (cmd.fire && per_ff[best_ff] != '0) begin
         exp_ff[best_ff]   <= bexp_ff + per_ff[best_ff];
         stamp_ff[best_ff] <= ins_ff;
      end
      if (cmd.fire) fslot_ff <= best_ff;
      if (cmd.load) was_ff <= 1'b0;
      else if (cmd.apply && rq_ff == REQ_CANCEL && id_ok) was_ff <= armed_ff[sid];
      if (cmd.scan_clr) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (!sts.scan_done) scan_ff <= scan_ff + 1'b1;
         if (take_cand) begin
            found_ff <= 1'b1;
            best_ff  <= cand;
            bexp_ff  <= cexp;
            bage_ff  <= cage;
         end
      end
      if (cmd.emit) begin
         odata_ff <= {7'b0000000, total_ff, armcnt_ff,
                      found_ff ? bexp_ff : {TIME_W{1'b0}},
                      fia_ff, was_ff, 4'(cmd.emit_fire ? fslot_ff : '0), cmd.emit_fire};
         olast_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         armed_ff  <= '0;
         ins_ff    <= '0;
         armcnt_ff <= '0;
         total_ff  <= '0;
         fia_ff    <= '0;
         full_ff   <= 1'b0;
      end else begin
         if (cmd.load) fia_ff <= '0;
         if (cmd.set_time) cur_ff <= ntime_ff;
         if (cmd.apply && id_ok) begin
            if (rq_ff == REQ_ARM) begin
               armed_ff[sid] <= 1'b1;
               ins_ff        <= ins_ff + 1'b1;
               if (!armed_ff[sid]) armcnt_ff <= armcnt_ff + 1'b1;
            end else if (rq_ff == REQ_CANCEL && armed_ff[sid]) begin
               armed_ff[sid] <= 1'b0;
               armcnt_ff     <= armcnt_ff - 1'b1;
            end
         end
         if (cmd.fire) begin
            total_ff <= total_ff + 1'b1;
            fia_ff   <= fia_ff + 1'b1;
            if (per_ff[best_ff] != '0) begin
               ins_ff <= ins_ff + 1'b1;
            end else begin
               armed_ff[best_ff] <= 1'b0;
               armcnt_ff         <= armcnt_ff - 1'b1;
            end
         end
         if (cmd.emit) full_ff <= 1'b1;
         else if (out_take) full_ff <= 1'b0;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      armcnt_ff <= CNT_W'(TIMER_SLOTS))
      else $error("armed count out of range");
   a_cnt_match: assert property (@(posedge clock) disable iff (reset)
      armcnt_ff == CNT_W'($countones(armed_ff)))
      else $error("armed count disagrees with armed bits");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !full_ff || out_take)
      else $error("result overwritten");

endmodule

/* src/timer_callout_queue.sv */
// ============================================================================
// timer_callout_queue: searched timer slot table with periodic re-arm
// Arms, cancels and fires timers; each firing is one result beat.
// ============================================================================
// A request that fires nothing gives its beat after one search over the sixteen
// slots at one per cycle. An advance fires each due slot in turn, with a fresh
// search after each firing, and gives one beat per firing.
// One request at a time is taken; a result held by the receiver stalls everything
// behind it.
// Reset (synchronous, active high) disarms every slot and clears all counters.
module timer_callout_queue (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,  // req_type
   input  logic [199:0]  req_tdata,  // timer_id[3:0], delay[67:4], period[131:68],
                                     // new_time[195:132], zero fill
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,  // is_fire, fired_slot, was_armed,
                                     // fired_in_advance, next_expiry, armed slots,
                                     // fire total, zero fill
   output logic          rsp_tlast
);
   import tcq_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        out_full;

   tcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_tvalid && req_tready),
      .req_ready (req_tready),
      .out_full  (out_full && !rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_type (req_tuser),
      .timer_id (req_tdata[3:0]),
      .delay    (req_tdata[67:4]),
      .period   (req_tdata[131:68]),
      .new_time (req_tdata[195:132]),
      .cmd      (cmd),
      .sts      (sts),
      .out_take (rsp_tready),
      .out_full (out_full),
      .out_data (rsp_tdata),
      .out_last (rsp_tlast)
   );

   assign rsp_tvalid = out_full;

endmodule
